// ===== rtl/mtep_pkg.sv =====
// mtep_pkg: types and constants of the midi track event parser
// shared by midi_track_event_parser_unit and the testbench; no dependencies

package mtep_pkg;

  // parse phase of the track byte stream
  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_META_TYPE = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_SYSEX_LEN = 4'd4,
    PH_SKIP      = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_DATA1     = 4'd7,
    PH_DATA2     = 4'd8
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // status and meta codes
  localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
  localparam logic [3:0] TYPE_PROG_CHG   = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
  localparam logic [27:0] TEMPO_LEN      = 28'd3;
  localparam logic [23:0] TEMPO_DEFAULT  = 24'd500000;

  // result queue
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic        note_on;
    logic [7:0]  velocity;
    logic [23:0] tempo_us;
    logic [31:0] max_end_tick;
    logic        last_of_run;
  } out_item_t;

endpackage

// ===== rtl/midi_track_event_parser_unit.sv =====
// midi_track_event_parser_unit: parses one midi track chunk, one byte per item
// depends on mtep_pkg for item structs, phase enum and codes
//
// usage
//   input channel: in_valid_i / in_stall_o carry in_data_i (track byte plus a
//   last-byte flag). an item is taken at a clock edge with valid high and
//   stall low.
//   output channel: out_valid_o / out_stall_i carry out_data_o (note, tempo or
//   track end results). a byte yields zero, one or two results; last_of_run
//   marks the final result of a byte.
//   results of a byte are written to the queue at the edge that takes the
//   byte. throughput: one byte per cycle while in_stall_o is low; the parse
//   state is updated in a single pass at the edge that takes the byte.
//   results wait in a four-entry queue; in_stall_o rises while fewer than two
//   entries are free, so a stalled receiver holds the head result steady and
//   back-pressure reaches the sender before the queue fills.
//   reset: queue empty, parser in the delta time phase with zero tick and no
//   running status, maximum end tick cleared. a track end clears all parse
//   state but keeps the maximum end tick across tracks.

module midi_track_event_parser_unit #(
  parameter int unsigned QueueDepth = mtep_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtep_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtep_pkg::out_item_t out_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // parse state
  mtep_pkg::phase_e phase_q, phase_d;
  logic [31:0] tick_q, tick_d;
  logic [27:0] qacc_q, qacc_d;
  logic [1:0]  qbytes_q, qbytes_d;
  logic [7:0]  run_status_q, run_status_d;
  logic [7:0]  cur_status_q, cur_status_d;
  logic [7:0]  meta_kind_q, meta_kind_d;
  logic [27:0] skip_q, skip_d;
  logic [23:0] held_q, held_d;
  logic        stopped_q, stopped_d;
  logic [31:0] max_q, max_d;

  // result queue
  mtep_pkg::out_item_t queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  logic in_fire, out_fire;
  logic [7:0] b;
  logic       last;

  // quantity byte helpers (delta times and lengths)
  logic [27:0] qacc_new;
  logic [1:0]  qbytes_new;
  logic        qdone;

  // result datapath
  logic [23:0] tempo_new;
  logic [27:0] skip_dec;
  logic [31:0] fin_tick;
  logic [31:0] max_new;
  logic        ev_valid;
  mtep_pkg::out_item_t ev_item, end_item;
  mtep_pkg::out_item_t slot0, slot1;
  logic [1:0]  wr_n;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign b        = in_data_i.track_byte;
  assign last     = in_data_i.last_byte;

  assign qacc_new   = {qacc_q[20:0], b[6:0]};
  assign qbytes_new = qbytes_q + 2'd1;
  assign qdone      = !b[7] || (qbytes_new == 2'd0);
  assign tempo_new  = {held_q[15:0], b};
  assign skip_dec   = skip_q - 28'd1;

  // final tick includes a delta that the last byte cuts off
  assign fin_tick = tick_q + ((!stopped_q && phase_q == mtep_pkg::PH_DELTA)
                              ? {4'd0, qacc_new} : 32'd0);
  assign max_new  = (fin_tick > max_q) ? fin_tick : max_q;

  // next parse state
  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    qacc_d       = qacc_q;
    qbytes_d     = qbytes_q;
    run_status_d = run_status_q;
    cur_status_d = cur_status_q;
    meta_kind_d  = meta_kind_q;
    skip_d       = skip_q;
    held_d       = held_q;
    stopped_d    = stopped_q;
    max_d        = max_q;
    if (in_fire) begin
      if (!stopped_q) begin
        unique case (phase_q)
          mtep_pkg::PH_STATUS: begin
            if (b[7]) begin
              if (b < mtep_pkg::STATUS_SYSTEM) begin
                run_status_d = b;
                cur_status_d = b;
                phase_d      = mtep_pkg::PH_DATA1;
              end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
                run_status_d = 8'd0;
                phase_d      = mtep_pkg::PH_SYSEX_LEN;
              end else if (b == mtep_pkg::STATUS_META) begin
                phase_d = mtep_pkg::PH_META_TYPE;
              end else begin
                // other system status: nothing consumed
                phase_d = mtep_pkg::PH_DELTA;
              end
            end else if (run_status_q == 8'd0) begin
              stopped_d = 1'b1;
            end else begin
              // running status: byte is the first data byte
              cur_status_d = run_status_q;
              if (run_status_q[7:4] == mtep_pkg::TYPE_PROG_CHG ||
                  run_status_q[7:4] == mtep_pkg::TYPE_CHAN_PRESS) begin
                phase_d = mtep_pkg::PH_DELTA;
              end else begin
                held_d  = {16'd0, b};
                phase_d = mtep_pkg::PH_DATA2;
              end
            end
          end
          mtep_pkg::PH_META_TYPE: begin
            meta_kind_d = b;
            if (b == mtep_pkg::META_END_TRACK) begin
              stopped_d = 1'b1;
            end else begin
              phase_d = mtep_pkg::PH_META_LEN;
            end
          end
          mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
            qacc_d   = qacc_new;
            qbytes_d = qbytes_new;
            if (qdone) begin
              qacc_d   = 28'd0;
              qbytes_d = 2'd0;
              if (qacc_new == 28'd0) begin
                phase_d = mtep_pkg::PH_DELTA;
              end else if (phase_q == mtep_pkg::PH_META_LEN &&
                           meta_kind_q == mtep_pkg::META_TEMPO &&
                           qacc_new == mtep_pkg::TEMPO_LEN) begin
                skip_d  = mtep_pkg::TEMPO_LEN;
                held_d  = 24'd0;
                phase_d = mtep_pkg::PH_TEMPO;
              end else begin
                skip_d  = qacc_new;
                phase_d = mtep_pkg::PH_SKIP;
              end
            end
          end
          mtep_pkg::PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 28'd0) begin
              phase_d = mtep_pkg::PH_DELTA;
            end
          end
          mtep_pkg::PH_TEMPO: begin
            held_d = tempo_new;
            skip_d = skip_dec;
            if (skip_dec == 28'd0) begin
              phase_d = mtep_pkg::PH_DELTA;
            end
          end
          mtep_pkg::PH_DATA1: begin
            if (cur_status_q[7:4] == mtep_pkg::TYPE_PROG_CHG ||
                cur_status_q[7:4] == mtep_pkg::TYPE_CHAN_PRESS) begin
              phase_d = mtep_pkg::PH_DELTA;
            end else begin
              held_d  = {16'd0, b};
              phase_d = mtep_pkg::PH_DATA2;
            end
          end
          mtep_pkg::PH_DATA2: begin
            phase_d = mtep_pkg::PH_DELTA;
          end
          default: begin
            // delta time quantity
            phase_d  = mtep_pkg::PH_DELTA;
            qacc_d   = qacc_new;
            qbytes_d = qbytes_new;
            if (qdone) begin
              tick_d   = tick_q + {4'd0, qacc_new};
              qacc_d   = 28'd0;
              qbytes_d = 2'd0;
              phase_d  = mtep_pkg::PH_STATUS;
            end
          end
        endcase
      end
      if (last) begin
        max_d        = max_new;
        phase_d      = mtep_pkg::PH_DELTA;
        tick_d       = 32'd0;
        qacc_d       = 28'd0;
        qbytes_d     = 2'd0;
        run_status_d = 8'd0;
        cur_status_d = 8'd0;
        meta_kind_d  = 8'd0;
        skip_d       = 28'd0;
        held_d       = 24'd0;
        stopped_d    = 1'b0;
      end
    end
  end

  // results of the byte
  always_comb begin
    ev_valid = 1'b0;
    ev_item  = '0;
    ev_item.tick = tick_q;
    if (!stopped_q) begin
      if (phase_q == mtep_pkg::PH_TEMPO && skip_dec == 28'd0) begin
        ev_valid         = 1'b1;
        ev_item.kind     = mtep_pkg::KIND_TEMPO;
        ev_item.tempo_us = (tempo_new != 24'd0) ? tempo_new : mtep_pkg::TEMPO_DEFAULT;
      end else if (phase_q == mtep_pkg::PH_DATA2 &&
                   (cur_status_q[7:4] == mtep_pkg::TYPE_NOTE_ON ||
                    cur_status_q[7:4] == mtep_pkg::TYPE_NOTE_OFF)) begin
        ev_valid            = 1'b1;
        ev_item.kind        = mtep_pkg::KIND_NOTE;
        ev_item.channel     = cur_status_q[3:0];
        ev_item.note_number = held_q[7:0];
        if (cur_status_q[7:4] == mtep_pkg::TYPE_NOTE_ON) begin
          ev_item.note_on  = (b != 8'd0);
          ev_item.velocity = b;
        end
      end
    end
    ev_item.last_of_run = !last;

    end_item              = '0;
    end_item.kind         = mtep_pkg::KIND_END;
    end_item.tick         = fin_tick;
    end_item.max_end_tick = max_new;
    end_item.last_of_run  = 1'b1;

    // pack results into consecutive queue slots
    slot0 = ev_valid ? ev_item : end_item;
    slot1 = end_item;
    wr_n  = in_fire ? ({1'b0, ev_valid} + {1'b0, last}) : 2'd0;
  end

  assign count_d = count_q + CntW'(wr_n) - CntW'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mtep_pkg::PH_DELTA;
      tick_q       <= '0;
      qacc_q       <= '0;
      qbytes_q     <= '0;
      run_status_q <= '0;
      cur_status_q <= '0;
      meta_kind_q  <= '0;
      skip_q       <= '0;
      held_q       <= '0;
      stopped_q    <= 1'b0;
      max_q        <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      qacc_q       <= qacc_d;
      qbytes_q     <= qbytes_d;
      run_status_q <= run_status_d;
      cur_status_q <= cur_status_d;
      meta_kind_q  <= meta_kind_d;
      skip_q       <= skip_d;
      held_q       <= held_d;
      stopped_q    <= stopped_d;
      max_q        <= max_d;
      wr_ptr_q     <= wr_ptr_q + PtrW'(wr_n);
      rd_ptr_q     <= rd_ptr_q + PtrW'(out_fire);
      count_q      <= count_d;
    end
  end

  // queue storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      queue_q[wr_ptr_q] <= slot0;
    end
    if (wr_n == 2'd2) begin
      queue_q[PtrW'(wr_ptr_q + PtrW'(1))] <= slot1;
    end
  end

  assign in_stall_o  = (count_q > CntW'(QueueDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CntW'($past(wr_n)) - CntW'($past(out_fire)))
    else $error("queue count out of step with writes and reads");

  a_track_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last) |=> (!stopped_q && phase_q == mtep_pkg::PH_DELTA &&
                           tick_q == 32'd0 && run_status_q == 8'd0))
    else $error("parse state not cleared after track end");

  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_q >= $past(max_q))
    else $error("maximum end tick decreased");

  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && stopped_q && !last) |-> wr_n == 2'd0)
    else $error("result written while parsing is stopped");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for midi_track_event_parser_unit
// depends on mtep_pkg and the unit under test; holds its own parse predictor

// predicts the results of each accepted track byte and checks what comes out
class track_scoreboard;
  mtep_pkg::phase_e    phase;
  logic [31:0]         tick_count;
  logic [27:0]         qty_accum;
  logic [1:0]          qty_bytes;
  logic [7:0]          run_status;
  logic [7:0]          current_status;
  logic [7:0]          meta_code;
  logic [27:0]         skip_left;
  logic [23:0]         held_data;
  bit                  stopped;
  logic [31:0]         end_tick_max;
  mtep_pkg::out_item_t expected_q[$];
  mtep_pkg::out_item_t byte_results[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned n_notes;
  int unsigned n_tempos;
  int unsigned n_ends;

  function new();
    clear_track();
    end_tick_max = '0;
    errors = 0;
    checked = 0;
    n_notes = 0;
    n_tempos = 0;
    n_ends = 0;
  endfunction

  function void clear_track();
    phase = mtep_pkg::PH_DELTA;
    tick_count = '0;
    qty_accum = '0;
    qty_bytes = '0;
    run_status = '0;
    current_status = '0;
    meta_code = '0;
    skip_left = '0;
    held_data = '0;
    stopped = 1'b0;
  endfunction

  // one more 7-bit group; a quantity closes on bit 7 clear or after four bytes
  function bit take_quantity(logic [7:0] b);
    qty_accum = {qty_accum[20:0], b[6:0]};
    qty_bytes = qty_bytes + 2'd1;
    return !b[7] || (qty_bytes == 2'd0);
  endfunction

  function void add_result(logic [1:0] kind, logic [31:0] tick, logic [3:0] chan,
                           logic [7:0] note, logic on, logic [7:0] vel,
                           logic [23:0] tempo, logic [31:0] max_end);
    mtep_pkg::out_item_t r;
    r.kind = kind;
    r.tick = tick;
    r.channel = chan;
    r.note_number = note;
    r.note_on = on;
    r.velocity = vel;
    r.tempo_us = tempo;
    r.max_end_tick = max_end;
    r.last_of_run = 1'b0;
    byte_results.push_back(r);
  endfunction

  function void first_data(logic [7:0] b);
    if (current_status[7:4] == mtep_pkg::TYPE_PROG_CHG ||
        current_status[7:4] == mtep_pkg::TYPE_CHAN_PRESS) begin
      phase = mtep_pkg::PH_DELTA;
    end else begin
      held_data = {16'd0, b};
      phase = mtep_pkg::PH_DATA2;
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [27:0] len;
    case (phase)
      mtep_pkg::PH_STATUS: begin
        if (b[7]) begin
          if (b < mtep_pkg::STATUS_SYSTEM) begin
            run_status = b;
            current_status = b;
            phase = mtep_pkg::PH_DATA1;
          end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
            run_status = '0;
            phase = mtep_pkg::PH_SYSEX_LEN;
          end else if (b == mtep_pkg::STATUS_META) begin
            phase = mtep_pkg::PH_META_TYPE;
          end else begin
            phase = mtep_pkg::PH_DELTA;
          end
        end else if (run_status == '0) begin
          stopped = 1'b1;
        end else begin
          current_status = run_status;
          first_data(b);
        end
      end
      mtep_pkg::PH_META_TYPE: begin
        meta_code = b;
        if (b == mtep_pkg::META_END_TRACK) begin
          stopped = 1'b1;
        end else begin
          phase = mtep_pkg::PH_META_LEN;
        end
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
        if (take_quantity(b)) begin
          len = qty_accum;
          qty_accum = '0;
          qty_bytes = '0;
          if (len == '0) begin
            phase = mtep_pkg::PH_DELTA;
          end else if (phase == mtep_pkg::PH_META_LEN && meta_code == mtep_pkg::META_TEMPO &&
                       len == mtep_pkg::TEMPO_LEN) begin
            skip_left = mtep_pkg::TEMPO_LEN;
            held_data = '0;
            phase = mtep_pkg::PH_TEMPO;
          end else begin
            skip_left = len;
            phase = mtep_pkg::PH_SKIP;
          end
        end
      end
      mtep_pkg::PH_SKIP: begin
        skip_left = skip_left - 28'd1;
        if (skip_left == '0) begin
          phase = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_TEMPO: begin
        held_data = {held_data[15:0], b};
        skip_left = skip_left - 28'd1;
        if (skip_left == '0) begin
          add_result(mtep_pkg::KIND_TEMPO, tick_count, '0, '0, 1'b0, '0,
                     (held_data != '0) ? held_data : mtep_pkg::TEMPO_DEFAULT, '0);
          n_tempos++;
          phase = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_DATA1: begin
        first_data(b);
      end
      mtep_pkg::PH_DATA2: begin
        if (current_status[7:4] == mtep_pkg::TYPE_NOTE_ON) begin
          add_result(mtep_pkg::KIND_NOTE, tick_count, current_status[3:0], held_data[7:0],
                     b != 8'd0, b, '0, '0);
          n_notes++;
        end else if (current_status[7:4] == mtep_pkg::TYPE_NOTE_OFF) begin
          add_result(mtep_pkg::KIND_NOTE, tick_count, current_status[3:0], held_data[7:0],
                     1'b0, '0, '0, '0);
          n_notes++;
        end
        phase = mtep_pkg::PH_DELTA;
      end
      default: begin
        phase = mtep_pkg::PH_DELTA;
        if (take_quantity(b)) begin
          tick_count = tick_count + {4'd0, qty_accum};
          qty_accum = '0;
          qty_bytes = '0;
          phase = mtep_pkg::PH_STATUS;
        end
      end
    endcase
  endfunction

  // called for every byte the unit takes
  function void note_byte(mtep_pkg::in_item_t item);
    logic [31:0]         fin;
    mtep_pkg::out_item_t r;
    byte_results.delete();
    if (!stopped) begin
      parse_byte(item.track_byte);
    end
    if (item.last_byte) begin
      fin = tick_count;
      if (!stopped && phase == mtep_pkg::PH_DELTA) begin
        fin = fin + {4'd0, qty_accum};
      end
      if (fin > end_tick_max) begin
        end_tick_max = fin;
      end
      add_result(mtep_pkg::KIND_END, fin, '0, '0, 1'b0, '0, '0, end_tick_max);
      n_ends++;
      clear_track();
    end
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last_of_run = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) begin
      expected_q.push_back(byte_results[i]);
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // called for every result the unit hands over
  function void check_result(mtep_pkg::out_item_t got);
    mtep_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      $error("result with nothing pending: kind %0d tick 0x%0h", got.kind, got.tick);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    compare_field("kind", want.kind, got.kind);
    compare_field("tick", want.tick, got.tick);
    compare_field("channel", want.channel, got.channel);
    compare_field("note_number", want.note_number, got.note_number);
    compare_field("note_on", want.note_on, got.note_on);
    compare_field("velocity", want.velocity, got.velocity);
    compare_field("tempo_us", want.tempo_us, got.tempo_us);
    compare_field("max_end_tick", want.max_end_tick, got.max_end_tick);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module tb;

  // roughly how many bytes the random part sends
  localparam int unsigned ItemTarget = 1700;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned StallLimit = 1000;
  // settle time after the last expected result
  localparam int unsigned TailCycles = 20;

  // channel message types and system codes the package does not name
  localparam logic [3:0] TYPE_POLY_PRESS    = 4'hA;
  localparam logic [3:0] TYPE_CONTROL       = 4'hB;
  localparam logic [3:0] TYPE_PITCH_BEND    = 4'hE;
  localparam logic [7:0] STATUS_SYS_FIRST   = 8'hF1;
  localparam logic [7:0] STATUS_SONG_SELECT = 8'hF3;
  localparam logic [7:0] STATUS_SYS_LAST    = 8'hFE;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  mtep_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  mtep_pkg::out_item_t out_data_o;

  track_scoreboard sb = new();

  // idle limits, redrawn per track so calm stretches alternate with busy ones
  int unsigned tx_gap_max = 0;
  int unsigned rx_stall_max = 0;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned tracks_sent = 0;

  // bytes of the track chunk being built, and the running status the builder assumes
  logic [7:0] trk_q[$];
  logic [7:0] tx_running = '0;

  always #1 clk_i = ~clk_i;

  midi_track_event_parser_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // both handshakes are observed in one process at the rising edge, so a byte
  // is always noted before any result of the same edge is checked
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(in_data_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        // receiver hold-off before the next result
        rx_hold = $urandom_range(0, rx_stall_max);
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver stall, changed only at the falling edge
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int unsigned pick_limit();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 16;
    endcase
  endfunction

  // data byte: mostly 7-bit, sometimes with bit 7 set, which the parser takes
  // as data anyway once it expects data
  function automatic logic [7:0] data_any();
    if ($urandom_range(0, 99) < 85) begin
      return 8'($urandom_range(0, 127));
    end
    return 8'($urandom);
  endfunction

  // variable-length quantity, padded with leading zero groups up to min_len
  function automatic void put_vlq(int unsigned v, int unsigned min_len);
    int unsigned n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) begin
      n++;
    end
    if (n < min_len) begin
      n = min_len;
    end
    for (int i = int'(n) - 1; i >= 0; i--) begin
      trk_q.push_back({i != 0, 7'((v >> (7 * i)) & 32'h7F)});
    end
  endfunction

  function automatic void put_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      put_vlq(0, 1);
    end else if (r < 50) begin
      put_vlq($urandom_range(0, 127), 1);
    end else if (r < 80) begin
      put_vlq($urandom_range(0, 16383), $urandom_range(1, 3));
    end else if (r < 92) begin
      put_vlq($urandom & 32'h0FFF_FFFF, 4);
    end else begin
      // overlong quantity: bit 7 set on all four bytes, closed by the count
      repeat (4) trk_q.push_back({1'b1, 7'($urandom)});
    end
  endfunction

  function automatic void put_event();
    int unsigned r;
    int unsigned len;
    logic [7:0]  s;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (r < 40) begin
        s = {($urandom_range(0, 1) != 0) ? mtep_pkg::TYPE_NOTE_ON : mtep_pkg::TYPE_NOTE_OFF,
             4'($urandom)};
      end else begin
        case ($urandom_range(0, 4))
          0: s = {TYPE_POLY_PRESS, 4'($urandom)};
          1: s = {TYPE_CONTROL, 4'($urandom)};
          2: s = {mtep_pkg::TYPE_PROG_CHG, 4'($urandom)};
          3: s = {mtep_pkg::TYPE_CHAN_PRESS, 4'($urandom)};
          default: s = {TYPE_PITCH_BEND, 4'($urandom)};
        endcase
      end
      if (tx_running[7] && tx_running < mtep_pkg::STATUS_SYSTEM &&
          $urandom_range(0, 2) == 0) begin
        // running status: first data byte must look like data
        s = tx_running;
        trk_q.push_back(8'($urandom_range(0, 127)));
      end else begin
        trk_q.push_back(s);
        tx_running = s;
        trk_q.push_back(data_any());
      end
      if (s[7:4] != mtep_pkg::TYPE_PROG_CHG && s[7:4] != mtep_pkg::TYPE_CHAN_PRESS) begin
        if (s[7:4] == mtep_pkg::TYPE_NOTE_ON && $urandom_range(0, 3) == 0) begin
          trk_q.push_back(8'h00);
        end else begin
          trk_q.push_back(data_any());
        end
      end
    end else if (r < 65) begin
      trk_q.push_back(mtep_pkg::STATUS_META);
      trk_q.push_back(mtep_pkg::META_TEMPO);
      trk_q.push_back(8'(mtep_pkg::TEMPO_LEN));
      if ($urandom_range(0, 4) == 0) begin
        repeat (3) trk_q.push_back(8'h00);
      end else begin
        repeat (3) trk_q.push_back(8'($urandom));
      end
    end else if (r < 75) begin
      // other meta events, including a tempo type with a wrong length
      b = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        b = mtep_pkg::META_TEMPO;
      end
      if (b == mtep_pkg::META_END_TRACK) begin
        b = mtep_pkg::META_TEMPO;
      end
      len = $urandom_range(0, 6);
      if (b == mtep_pkg::META_TEMPO && len == mtep_pkg::TEMPO_LEN) begin
        len++;
      end
      trk_q.push_back(mtep_pkg::STATUS_META);
      trk_q.push_back(b);
      put_vlq(len, $urandom_range(1, 2));
      repeat (len) trk_q.push_back(8'($urandom));
    end else if (r < 83) begin
      trk_q.push_back(($urandom_range(0, 1) != 0) ? mtep_pkg::STATUS_SYSEX :
                                                    mtep_pkg::STATUS_ESCAPE);
      len = $urandom_range(0, 8);
      put_vlq(len, $urandom_range(1, 2));
      repeat (len) trk_q.push_back(8'($urandom));
      tx_running = '0;
    end else begin
      // lone system status: no data, running status untouched
      b = 8'($urandom_range(STATUS_SYS_FIRST, STATUS_SYS_LAST));
      if (b == mtep_pkg::STATUS_ESCAPE) begin
        b = STATUS_SYS_FIRST;
      end
      trk_q.push_back(b);
    end
  endfunction

  // a well-formed track; ends on end-of-track, on an event, or inside a delta
  function automatic void build_track();
    int unsigned r;
    trk_q.delete();
    tx_running = '0;
    repeat ($urandom_range(1, 25)) begin
      put_delta();
      put_event();
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_delta();
      trk_q.push_back(mtep_pkg::STATUS_META);
      trk_q.push_back(mtep_pkg::META_END_TRACK);
      trk_q.push_back(8'h00);
      // trailing bytes after end-of-track are ignored
      repeat ($urandom_range(0, 2)) trk_q.push_back(8'($urandom));
    end else if (r < 85) begin
      repeat ($urandom_range(1, 3)) trk_q.push_back({1'b1, 7'($urandom)});
    end
  endfunction

  // one byte over the input handshake; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned        gap;
    mtep_pkg::in_item_t item;
    gap = $urandom_range(0, tx_gap_max);
    item.track_byte = b;
    item.last_byte = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_track();
    foreach (trk_q[i]) begin
      send_byte(trk_q[i], i == trk_q.size() - 1);
    end
    tracks_sent++;
  endtask

  initial begin : stimulus
    int unsigned f;
    int unsigned k;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: note on at extremes, running status with velocity 0, overlong
    // delta then note off with release velocity, zero tempo, lone system
    // status, empty sysex, then a data byte with no running status left
    trk_q = '{8'h00, {mtep_pkg::TYPE_NOTE_ON, 4'h0}, 8'h00, 8'hFF,
              8'h00, 8'h7F, 8'h00,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, {mtep_pkg::TYPE_NOTE_OFF, 4'hF}, 8'hFF, 8'h01,
              8'h00, mtep_pkg::STATUS_META, mtep_pkg::META_TEMPO, 8'(mtep_pkg::TEMPO_LEN),
              8'h00, 8'h00, 8'h00,
              8'h00, STATUS_SONG_SELECT,
              8'h00, mtep_pkg::STATUS_SYSEX, 8'h00,
              8'h00, 8'h40};
    send_track();
    tx_gap_max = 16;
    rx_stall_max = 16;
    // program change, end-of-track, a byte ignored after it
    trk_q = '{8'h10, {mtep_pkg::TYPE_PROG_CHG, 4'h5}, 8'h20, 8'h00, mtep_pkg::STATUS_META,
              mtep_pkg::META_END_TRACK, 8'h00, 8'h7F};
    send_track();
    // a delta cut off by the end of the chunk still counts
    trk_q = '{8'h85};
    send_track();

    // random tracks: mostly well formed, some cut short, some broken or noise
    while (bytes_sent < ItemTarget) begin
      tx_gap_max = pick_limit();
      rx_stall_max = pick_limit();
      f = $urandom_range(0, 99);
      if (f < 88) begin
        build_track();
        if (f >= 76) begin
          k = $urandom_range(1, trk_q.size());
          trk_q = trk_q[0:k-1];
        end
      end else if (f < 94) begin
        trk_q.delete();
        put_delta();
        trk_q.push_back(8'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 6)) trk_q.push_back(8'($urandom));
      end else begin
        trk_q.delete();
        repeat ($urandom_range(1, 30)) trk_q.push_back(8'($urandom));
      end
      send_track();
    end
    in_valid_i <= 1'b0;

    // drain, then give a stray extra result time to show up
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("tb: %0d bytes in %0d tracks, %0d results checked", bytes_sent, tracks_sent,
             sb.checked);
    $display("tb: %0d note events, %0d tempo changes, %0d track ends, max end tick 0x%0h",
             sb.n_notes, sb.n_tempos, sb.n_ends, sb.end_tick_max);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
